// File: sv/aes_ctr_pkg.sv
`default_nettype none
package aes_ctr_pkg;

  localparam int ROUND_COUNT = 14;
  localparam int KEY_WORDS = 8;
  localparam int RK_WORDS = 4 * (ROUND_COUNT + 1);
  localparam int RK_AW = 6;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_KEY_3 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_2 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_1 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_0 = 2'd3;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_CRYPT = 1'b1;

  typedef enum logic [2:0] {
    ST_EXPAND,
    ST_IDLE,
    ST_PRIME,
    ST_ROUND
  } state_t;

  // key expansion request/status between top and expander
  typedef struct packed {
    logic busy;
    logic       we;
    logic [RK_AW-1:0] waddr;
    logic [31:0] wdata;
  } kexp_t;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    return t[a];
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

endpackage
`default_nettype wire

// File: sv/aes_ctr_keyexp.sv
`default_nettype none
module aes_ctr_keyexp #(
  parameter int ROUND_COUNT = aes_ctr_pkg::ROUND_COUNT
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  input  wire logic [255:0] key,
  output aes_ctr_pkg::kexp_t kx
);
  localparam int RKW = 4 * (ROUND_COUNT + 1);

  logic [5:0]   idx_r, idx_nxt;
  logic         busy_r, busy_nxt;
  logic [255:0] win_r, win_nxt;   // last eight words, word i-8 in top bits
  logic [7:0]   rcon_r, rcon_nxt;
  logic [31:0]  t, nw;

  always_comb begin
    t = win_r[31:0];
    if (idx_r[2:0] == 3'd0) t = aes_ctr_pkg::sub_word({t[23:0], t[31:24]}) ^ {rcon_r, 24'h0};
    else if (idx_r[2:0] == 3'd4) t = aes_ctr_pkg::sub_word(t);
    nw = (idx_r < 6'd8) ? key[255 - 32*idx_r[2:0] -: 32] : (win_r[255:224] ^ t);
    idx_nxt = idx_r;
    busy_nxt = busy_r;
    win_nxt = win_r;
    rcon_nxt = rcon_r;
    if (start) begin
      idx_nxt = '0;
      busy_nxt = 1'b1;
      rcon_nxt = 8'h01;
    end else if (busy_r) begin
      win_nxt = {win_r[223:0], nw};
      if (idx_r >= 6'd8 && idx_r[2:0] == 3'd0) rcon_nxt = aes_ctr_pkg::xtime(rcon_r);
      idx_nxt = idx_r + 6'd1;
      if (idx_r == 6'(RKW - 1)) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      busy_r <= 1'b1;
      rcon_r <= 8'h01;
    end else begin
      idx_r <= idx_nxt;
      busy_r <= busy_nxt;
      rcon_r <= rcon_nxt;
    end
    win_r <= win_nxt;
  end

  assign kx.busy = busy_r | start;
  assign kx.we = busy_r & ~start;
  assign kx.waddr = idx_r;
  assign kx.wdata = nw;
endmodule
`default_nettype wire

// File: sv/aes_ctr_round.sv
`default_nettype none
module aes_ctr_round (
  input  wire logic [127:0] s_in,
  input  wire logic         last,
  output logic      [127:0] s_out
);
  logic [7:0] b [16];
  logic [7:0] t [16];
  logic [7:0] a0, a1, a2, a3, al;

  always_comb begin
    for (int i = 0; i < 16; i++) b[i] = s_in[127 - 8*i -: 8];
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        t[4*c + r] = aes_ctr_pkg::sbox(b[4*((c + r) % 4) + r]);
    s_out = '0;
    for (int c = 0; c < 4; c++) begin
      a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
      al = a0 ^ a1 ^ a2 ^ a3;
      if (!last) begin
        a0 = t[4*c]   ^ al ^ aes_ctr_pkg::xtime(t[4*c]   ^ t[4*c+1]);
        a1 = t[4*c+1] ^ al ^ aes_ctr_pkg::xtime(t[4*c+1] ^ t[4*c+2]);
        a2 = t[4*c+2] ^ al ^ aes_ctr_pkg::xtime(t[4*c+2] ^ t[4*c+3]);
        a3 = t[4*c+3] ^ al ^ aes_ctr_pkg::xtime(t[4*c+3] ^ t[4*c]);
      end
      s_out[127 - 32*c -: 32] = {a0, a1, a2, a3};
    end
  end
endmodule
`default_nettype wire

// File: sv/aes256_ctr_cipher.sv
// channel | dir | handshake          | payload
// in      | in  | in_tvalid/tready   | tuser opcode, tdata block
// out     | out | out_tvalid/tready  | tdata result
// cfg     | in  | cfg_valid/ready    | cfg_index, cfg_data
// a crypt word reads one round key word per cycle, 60 reads over 15 round keys, and
// applies a round every fourth word, then forms the result; no new word is taken until
// the result is formed. a load word only sets the counter; the block stays idle.
// after reset and after each key write the schedule fills the round key memory;
// no word is accepted meanwhile.
// the result waits in an output register; a crypt word that finishes while that
// register is still full holds until out_tready. reset is synchronous, active low.
`default_nettype none
module aes256_ctr_cipher #(
  parameter int ROUND_COUNT = aes_ctr_pkg::ROUND_COUNT
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [127:0] in_tdata,   // block_lo, block_hi
  input  wire logic         in_tuser,   // opcode
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic      [127:0] out_tdata,  // result_lo, result_hi
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [63:0]  cfg_data
);
  localparam int RKW = 4 * (ROUND_COUNT + 1);

  aes_ctr_pkg::state_t st_r, st_nxt;
  aes_ctr_pkg::kexp_t  kx;

  logic [255:0] key_r, key_nxt;
  logic         kstart;
  logic [127:0] ctr_r, ctr_nxt;
  logic [127:0] blk_r, blk_nxt;
  logic [127:0] s_r, s_nxt, rnd_out;
  logic [127:0] res_r, res_nxt;
  logic         out_valid_r, out_valid_nxt;
  logic [5:0]   ra_r, ra_nxt;
  logic [31:0]  rk_mem [RKW];
  logic [31:0]  rk_q;
  logic [95:0]  kacc_r, kacc_nxt;
  logic [1:0]   col_r, col_nxt;
  logic [3:0]   rnd_r, rnd_nxt;
  logic         rd_valid_r, rd_valid_nxt;

  always_ff @(posedge clk) begin
    if (kx.we) rk_mem[kx.waddr] <= kx.wdata;
    rk_q <= rk_mem[ra_r];
  end

  aes_ctr_keyexp #(.ROUND_COUNT(ROUND_COUNT)) u_kexp (
    .clk(clk), .rst_n(rst_n), .start(kstart), .key(key_r), .kx(kx)
  );

  aes_ctr_round u_round (.s_in(s_r), .last(rnd_r == 4'(ROUND_COUNT)), .s_out(rnd_out));

  assign cfg_ready = 1'b1;
  assign in_tready = (st_r == aes_ctr_pkg::ST_IDLE) && !kx.busy;
  assign out_tvalid = out_valid_r;
  assign out_tdata = {res_r[63:0], res_r[127:64]};

  always_comb begin
    st_nxt = st_r;
    key_nxt = key_r;
    kstart = 1'b0;
    ctr_nxt = ctr_r;
    blk_nxt = blk_r;
    s_nxt = s_r;
    res_nxt = res_r;
    out_valid_nxt = out_valid_r & ~out_tready;
    ra_nxt = ra_r;
    kacc_nxt = kacc_r;
    col_nxt = col_r;
    rnd_nxt = rnd_r;
    rd_valid_nxt = 1'b0;
    if (cfg_valid) begin
      kstart = 1'b1;
      case (cfg_index)
        aes_ctr_pkg::REG_KEY_3: key_nxt[255:192] = cfg_data;
        aes_ctr_pkg::REG_KEY_2: key_nxt[191:128] = cfg_data;
        aes_ctr_pkg::REG_KEY_1: key_nxt[127:64] = cfg_data;
        aes_ctr_pkg::REG_KEY_0: key_nxt[63:0] = cfg_data;
        default: kstart = 1'b0;
      endcase
    end
    case (st_r)
      aes_ctr_pkg::ST_EXPAND: if (!kx.busy) st_nxt = aes_ctr_pkg::ST_IDLE;
      aes_ctr_pkg::ST_IDLE: begin
        if (in_tvalid && in_tready) begin
          if (in_tuser == aes_ctr_pkg::OP_LOAD) begin
            ctr_nxt = {in_tdata[63:0], in_tdata[127:64]};
          end else begin
            blk_nxt = {in_tdata[63:0], in_tdata[127:64]};
            s_nxt = ctr_r;
            ra_nxt = '0;
            col_nxt = '0;
            rnd_nxt = '0;
            st_nxt = aes_ctr_pkg::ST_ROUND;
          end
        end
      end
      aes_ctr_pkg::ST_ROUND: begin
        // one key word per cycle; ra_r is read out through a register, so its word arrives in the cycle after
        rd_valid_nxt = 1'b1;
        if (ra_r != 6'(RKW - 1)) ra_nxt = ra_r + 6'd1;
        if (rd_valid_r) begin
          col_nxt = col_r + 2'd1;
          if (col_r != 2'd3) begin
            kacc_nxt = {kacc_r[63:0], rk_q};
          end else begin
            if (rnd_r == 4'd0) s_nxt = s_r ^ {kacc_r, rk_q};
            else s_nxt = rnd_out ^ {kacc_r, rk_q};
            rnd_nxt = rnd_r + 4'd1;
            if (rnd_r == 4'(ROUND_COUNT)) st_nxt = aes_ctr_pkg::ST_PRIME;
          end
        end
      end
      aes_ctr_pkg::ST_PRIME: begin
        // hold until the output register is free
        if (!out_valid_r || out_tready) begin
          res_nxt = s_r ^ blk_r;
          out_valid_nxt = 1'b1;
          ctr_nxt = ctr_r + 128'd1;
          st_nxt = aes_ctr_pkg::ST_IDLE;
        end
      end
      default: st_nxt = aes_ctr_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= aes_ctr_pkg::ST_EXPAND;
      key_r <= '0;
      ctr_r <= '0;
      out_valid_r <= 1'b0;
      rd_valid_r <= 1'b0;
      ra_r <= '0;
      col_r <= '0;
      rnd_r <= '0;
    end else begin
      st_r <= st_nxt;
      key_r <= key_nxt;
      ctr_r <= ctr_nxt;
      out_valid_r <= out_valid_nxt;
      rd_valid_r <= rd_valid_nxt;
      ra_r <= ra_nxt;
      col_r <= col_nxt;
      rnd_r <= rnd_nxt;
    end
    blk_r <= blk_nxt;
    s_r <= s_nxt;
    res_r <= res_nxt;
    kacc_r <= kacc_nxt;
  end
endmodule
`default_nettype wire
